// ----- rtl/hsts_pkg.sv -----
// ----------------------------------------------------------------------------
// hsts_pkg
// Shared codes and types of the hierarchical state transition sequencer.
// ----------------------------------------------------------------------------
package hsts_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_BEGIN = 2'd1;
    localparam logic [1:0] OP_REQ   = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [1:0] KIND_EXIT   = 2'd0;
    localparam logic [1:0] KIND_ENTER  = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    localparam logic [5:0] STATE_NONE = 6'h3f;

    localparam logic REG_STATE_COUNT = 1'b0;
    localparam logic REG_SELF_REINIT = 1'b1;

    localparam int MaxRecords = 18;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RES_RQ,
        ST_RES_RSP,
        ST_RES_DONE,
        ST_LEAF_RQ,
        ST_LEAF_RSP,
        ST_ANC_RQ,
        ST_ANC_RSP,
        ST_LCA,
        ST_SRCH_RQ,
        ST_SRCH_RSP,
        ST_PATH_RQ,
        ST_PATH_RSP,
        ST_TICK_RSP,
        ST_COMMIT,
        ST_EMIT
    } seq_state_t;

endpackage

// ----- rtl/hierarchical_state_transition_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// hierarchical_state_transition_sequencer_unit
// State tree sequencer: table writes, begin, transition requests and ticks.
// ----------------------------------------------------------------------------
// Input items arrive on s_valid/s_ready; each one yields one or more record
// items on m_valid/m_ready, the final one flagged by m_last. Registers
// state_count and self_reinit are written on the cfg_ channel, which is
// always ready. One item is processed at a time: s_ready is high only while
// the sequencer idles. The state table lives in one memory with a registered
// read; every walk step (resolve through initial children, leaf scan,
// ancestor list, common ancestor search, entry path) has a request state
// and a response state. A tick whose timeout fires goes on as a request
// to its timeout target. Records leave at one per cycle while the receiver
// is ready. When the receiver stalls, the output register holds its record
// and the sequencer waits. Reset puts the leaf at zero, the previous leaf
// at none, the tick count at zero; table contents are not cleared and must
// be written before use.
// ----------------------------------------------------------------------------
module hierarchical_state_transition_sequencer_unit
    import hsts_pkg::*;
#(
    parameter int MAX_STATES   = 32,
    parameter int MAX_DEPTH    = 8,
    parameter int TIMEOUT_BITS = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_index,
    input  logic [5:0]              cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_operation,
    input  logic [4:0]              s_state_index,
    input  logic signed [5:0]       s_parent_value,
    input  logic signed [5:0]       s_initial_child_value,
    input  logic [TIMEOUT_BITS-1:0] s_timeout_value,
    input  logic signed [5:0]       s_timeout_target_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [1:0]              m_record_kind,
    output logic signed [5:0]       m_record_state,
    output logic [4:0]              m_active_state,
    output logic signed [5:0]       m_prior_state,
    output logic                    m_last
);

    localparam int IdxW   = $clog2(MAX_STATES);
    localparam int CntW   = $clog2(MAX_STATES + 1);
    localparam int DepthW = $clog2(MAX_DEPTH + 2);
    localparam int AIdxW  = $clog2(MAX_DEPTH + 1);
    localparam int RecW   = $clog2(2 * MAX_DEPTH + 3);
    localparam int EntW   = 18 + TIMEOUT_BITS;
    localparam logic [TIMEOUT_BITS-1:0] TickMax = '1;

    function automatic logic node_ok(logic [5:0] v);
        return !v[5] && (32'(v[4:0]) < MAX_STATES);
    endfunction

    function automatic logic [IdxW-1:0] node_addr(logic [5:0] v);
        return IdxW'(v[4:0]);
    endfunction

    function automatic logic [5:0] norm6(logic [5:0] v);
        return v[5] ? STATE_NONE : v;
    endfunction

    // table memory: {parent, initial child, timeout, timeout target}
    logic [EntW-1:0] table_mem [MAX_STATES];
    logic [EntW-1:0] mem_rdata;
    logic [IdxW-1:0] rd_addr;
    logic            mem_we;
    logic [IdxW-1:0] wr_addr;
    logic [EntW-1:0] wr_data;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[wr_addr] <= wr_data;
        end
        mem_rdata <= table_mem[rd_addr];
    end

    logic [5:0]              rd_parent;
    logic [5:0]              rd_initial;
    logic [TIMEOUT_BITS-1:0] rd_timeout;
    logic [5:0]              rd_target;

    assign rd_parent  = mem_rdata[EntW-1 -: 6];
    assign rd_initial = mem_rdata[EntW-7 -: 6];
    assign rd_timeout = mem_rdata[TIMEOUT_BITS+5 : 6];
    assign rd_target  = mem_rdata[5:0];

    seq_state_t              state_reg, state_next;
    logic [5:0]              count_reg, count_next;
    logic                    reinit_reg, reinit_next;
    logic [4:0]              cur_reg, cur_next;
    logic [5:0]              prev_reg, prev_next;
    logic [TIMEOUT_BITS-1:0] elapsed_reg, elapsed_next;
    logic                    begin_reg, begin_next;
    logic [5:0]              node_reg, node_next;
    logic [5:0]              target_reg, target_next;
    logic [5:0]              lca_reg, lca_next;
    logic [DepthW-1:0]       cnt_reg, cnt_next;
    logic [CntW-1:0]         scan_reg, scan_next;
    logic [DepthW-1:0]       depth_reg, depth_next;
    logic [DepthW-1:0]       plen_reg, plen_next;
    logic [5:0]              anc_reg [MAX_DEPTH+1];
    logic [5:0]              anc_next [MAX_DEPTH+1];
    logic [5:0]              path_reg [MAX_DEPTH+1];
    logic [5:0]              path_next [MAX_DEPTH+1];
    logic [RecW-1:0]         total_reg, total_next;
    logic [RecW-1:0]         rec_reg, rec_next;
    logic                    single_reg, single_next;
    logic [1:0]              skind_reg, skind_next;
    logic                    m_valid_reg, m_valid_next;
    logic [1:0]              m_kind_reg, m_kind_next;
    logic [5:0]              m_state_reg, m_state_next;
    logic [4:0]              m_active_reg, m_active_next;
    logic [5:0]              m_prior_reg, m_prior_next;
    logic                    m_last_reg, m_last_next;

    logic [CntW-1:0]   used;
    logic [DepthW-1:0] exit_len;
    logic              anc_hit;
    logic [RecW-1:0]   rec_sum;
    logic [RecW-1:0]   path_pos;
    logic              rd_ok;

    assign used = (32'(count_reg) > MAX_STATES) ? CntW'(MAX_STATES) : CntW'(count_reg);
    assign rd_ok = node_ok(node_reg);

    // exits stop at the first ancestor equal to the common ancestor
    always_comb begin
        exit_len = depth_reg;
        anc_hit  = 1'b0;
        for (int i = MAX_DEPTH; i >= 0; i--) begin
            if (32'(i) < 32'(depth_reg) && anc_reg[i] == lca_reg) begin
                exit_len = DepthW'(i);
            end
        end
        for (int i = 0; i <= MAX_DEPTH; i++) begin
            if (32'(i) < 32'(depth_reg) && anc_reg[i] == node_reg) begin
                anc_hit = 1'b1;
            end
        end
    end

    assign rec_sum  = RecW'(exit_len) + RecW'(plen_reg);
    assign path_pos = RecW'(plen_reg) - RecW'(1) - (rec_reg - RecW'(exit_len));

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        reinit_next  = reinit_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        elapsed_next = elapsed_reg;
        begin_next   = begin_reg;
        node_next    = node_reg;
        target_next  = target_reg;
        lca_next     = lca_reg;
        cnt_next     = cnt_reg;
        scan_next    = scan_reg;
        depth_next   = depth_reg;
        plen_next    = plen_reg;
        anc_next     = anc_reg;
        path_next    = path_reg;
        total_next   = total_reg;
        rec_next     = rec_reg;
        single_next  = single_reg;
        skind_next   = skind_reg;
        m_valid_next  = m_valid_reg;
        m_kind_next   = m_kind_reg;
        m_state_next  = m_state_reg;
        m_active_next = m_active_reg;
        m_prior_next  = m_prior_reg;
        m_last_next   = m_last_reg;
        mem_we  = 1'b0;
        wr_addr = IdxW'(s_state_index);
        wr_data = {norm6(s_parent_value), norm6(s_initial_child_value),
                   s_timeout_value, norm6(s_timeout_target_value)};
        rd_addr = node_addr(node_reg);

        if (cfg_valid) begin
            case (cfg_index)
                REG_STATE_COUNT: count_next  = cfg_data;
                REG_SELF_REINIT: reinit_next = cfg_data[0];
                default:         count_next  = count_reg;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                rd_addr = node_addr({1'b0, cur_reg});
                if (s_valid) begin
                    single_next = 1'b1;
                    skind_next  = KIND_DONE;
                    total_next  = RecW'(1);
                    rec_next    = '0;
                    node_next   = {1'b0, s_state_index};
                    cnt_next    = '0;
                    begin_next  = (s_operation == OP_BEGIN);
                    case (s_operation)
                        OP_WRITE: begin
                            mem_we     = (32'(s_state_index) < MAX_STATES);
                            state_next = ST_EMIT;
                        end
                        OP_BEGIN, OP_REQ: begin
                            if (32'(s_state_index) < 32'(used)) begin
                                state_next = ST_RES_RQ;
                            end else begin
                                skind_next = KIND_REJECT;
                                state_next = ST_EMIT;
                            end
                        end
                        OP_TICK: begin
                            if (elapsed_reg != TickMax) begin
                                elapsed_next = elapsed_reg + 1'b1;
                            end
                            node_next  = {1'b0, cur_reg};
                            state_next = ST_TICK_RSP;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            ST_TICK_RSP: begin
                if (rd_ok && rd_timeout != '0 && elapsed_reg >= rd_timeout
                        && !rd_target[5]) begin
                    node_next  = rd_target;
                    cnt_next   = '0;
                    state_next = ST_RES_RQ;
                end else begin
                    state_next = ST_EMIT;
                end
            end

            // descend through initial children
            ST_RES_RQ: begin
                if (32'(cnt_reg) > MAX_DEPTH) begin
                    state_next = ST_RES_DONE;
                end else begin
                    state_next = ST_RES_RSP;
                end
            end

            ST_RES_RSP: begin
                if (!rd_ok || rd_initial[5]) begin
                    state_next = ST_RES_DONE;
                end else begin
                    node_next  = rd_initial;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_RES_RQ;
                end
            end

            ST_RES_DONE: begin
                target_next = node_reg;
                depth_next  = '0;
                if (begin_reg) begin
                    scan_next  = '0;
                    state_next = ST_LEAF_RQ;
                end else begin
                    node_next  = {1'b0, cur_reg};
                    state_next = ST_ANC_RQ;
                end
            end

            // a begin target must have no children among the used states
            ST_LEAF_RQ: begin
                rd_addr = scan_reg[IdxW-1:0];
                if (scan_reg == used) begin
                    lca_next   = STATE_NONE;
                    node_next  = target_reg;
                    plen_next  = '0;
                    state_next = ST_PATH_RQ;
                end else begin
                    state_next = ST_LEAF_RSP;
                end
            end

            ST_LEAF_RSP: begin
                if (rd_parent == target_reg) begin
                    skind_next = KIND_REJECT;
                    state_next = ST_EMIT;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_LEAF_RQ;
                end
            end

            ST_ANC_RQ: begin
                anc_next[depth_reg[AIdxW-1:0]] = node_reg;
                depth_next = depth_reg + 1'b1;
                state_next = ST_ANC_RSP;
            end

            ST_ANC_RSP: begin
                if (!rd_ok || rd_parent[5] || 32'(depth_reg) > MAX_DEPTH) begin
                    state_next = ST_LCA;
                end else begin
                    node_next  = rd_parent;
                    state_next = ST_ANC_RQ;
                end
            end

            ST_LCA: begin
                if (reinit_reg && {1'b0, cur_reg} == target_reg) begin
                    // parent of the current leaf is the second ancestor
                    lca_next   = (32'(depth_reg) > 1) ? anc_reg[1] : STATE_NONE;
                    node_next  = target_reg;
                    plen_next  = '0;
                    state_next = ST_PATH_RQ;
                end else begin
                    node_next  = target_reg;
                    cnt_next   = '0;
                    state_next = ST_SRCH_RQ;
                end
            end

            ST_SRCH_RQ: begin
                if (node_reg[5] || 32'(cnt_reg) > MAX_DEPTH) begin
                    lca_next   = STATE_NONE;
                    node_next  = target_reg;
                    plen_next  = '0;
                    state_next = ST_PATH_RQ;
                end else if (anc_hit) begin
                    lca_next   = node_reg;
                    node_next  = target_reg;
                    plen_next  = '0;
                    state_next = ST_PATH_RQ;
                end else begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_SRCH_RSP;
                end
            end

            ST_SRCH_RSP: begin
                node_next  = rd_ok ? rd_parent : STATE_NONE;
                state_next = ST_SRCH_RQ;
            end

            ST_PATH_RQ: begin
                if (node_reg[5] || node_reg == lca_reg || 32'(plen_reg) > MAX_DEPTH) begin
                    state_next = ST_COMMIT;
                end else begin
                    path_next[plen_reg[AIdxW-1:0]] = node_reg;
                    plen_next  = plen_reg + 1'b1;
                    state_next = ST_PATH_RSP;
                end
            end

            ST_PATH_RSP: begin
                node_next  = rd_ok ? rd_parent : STATE_NONE;
                state_next = ST_PATH_RQ;
            end

            ST_COMMIT: begin
                if (begin_reg) begin
                    depth_next = '0;
                    prev_next  = STATE_NONE;
                end else begin
                    prev_next  = {1'b0, cur_reg};
                end
                cur_next     = target_reg[4:0];
                elapsed_next = '0;
                // begin has no exits; depth cleared so exit_len reads zero next cycle
                if (rec_sum == '0) begin
                    single_next = 1'b1;
                    skind_next  = KIND_DONE;
                    total_next  = RecW'(1);
                end else begin
                    single_next = 1'b0;
                    total_next  = (32'(rec_sum) > MaxRecords) ? RecW'(MaxRecords) : rec_sum;
                end
                rec_next   = '0;
                state_next = ST_EMIT;
            end

            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_active_next = cur_reg;
                    m_prior_next  = prev_reg;
                    m_last_next   = (rec_reg == total_reg - 1'b1);
                    if (single_reg) begin
                        m_kind_next  = skind_reg;
                        m_state_next = STATE_NONE;
                    end else if (rec_reg < RecW'(exit_len)) begin
                        m_kind_next  = KIND_EXIT;
                        m_state_next = anc_reg[rec_reg[AIdxW-1:0]];
                    end else begin
                        m_kind_next  = KIND_ENTER;
                        m_state_next = path_reg[path_pos[AIdxW-1:0]];
                    end
                    rec_next = rec_reg + 1'b1;
                    if (rec_reg == total_reg - 1'b1) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= 6'd1;
            reinit_reg  <= 1'b0;
            cur_reg     <= '0;
            prev_reg    <= STATE_NONE;
            elapsed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            reinit_reg  <= reinit_next;
            cur_reg     <= cur_next;
            prev_reg    <= prev_next;
            elapsed_reg <= elapsed_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        begin_reg    <= begin_next;
        node_reg     <= node_next;
        target_reg   <= target_next;
        lca_reg      <= lca_next;
        cnt_reg      <= cnt_next;
        scan_reg     <= scan_next;
        depth_reg    <= depth_next;
        plen_reg     <= plen_next;
        anc_reg      <= anc_next;
        path_reg     <= path_next;
        total_reg    <= total_next;
        rec_reg      <= rec_next;
        single_reg   <= single_next;
        skind_reg    <= skind_next;
        m_kind_reg   <= m_kind_next;
        m_state_reg  <= m_state_next;
        m_active_reg <= m_active_next;
        m_prior_reg  <= m_prior_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_record_kind  = m_kind_reg;
    assign m_record_state = m_state_reg;
    assign m_active_state = m_active_reg;
    assign m_prior_state  = m_prior_reg;
    assign m_last         = m_last_reg;

endmodule
